// ===== rtl/core/dspp_pkg.sv =====
// Shared types, constants and microcode program for the degree sine plot point block.
package dspp_pkg;

  // Field widths of the request and result channels
  localparam int ANGLE_W = 10;
  localparam int SINE_W  = 16;
  localparam int PIX_W   = 9;
  localparam int COLOR_W = 4;

  // Parameter defaults
  localparam int DEF_TERMS     = 16;
  localparam int DEF_FRAC_BITS = 14;

  // Working format and fixed datapath widths
  localparam int WORK_FRAC = 20;
  localparam int RAD_W     = 24;  // |angle| * deg-to-rad in Q20
  localparam int SQ_W      = 27;  // square of the radians in Q20
  localparam int TERM_W    = 32;  // one series term in Q20
  localparam int SUM_W     = 34;  // signed running sum in Q20
  localparam int MAG_W     = 33;  // magnitude of the sum
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 27;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_W     = 12;  // series divisor (2k-2)(2k-1)
  localparam int KIDX_W    = 6;   // term index wide enough for the largest term count
  localparam int DIG_BITS  = 8;   // quotient bits resolved per divider cycle
  localparam int YOFF_W    = 7;

  localparam logic [14:0]        DEG_TO_RAD_Q20 = 15'd18301;
  localparam logic [6:0]         Y_SCALE        = 7'd100;
  localparam logic [PIX_W-1:0]   ORIGIN_Y       = 9'd240;
  localparam logic signed [10:0] ORIGIN_X       = 11'sd320;
  localparam logic [COLOR_W-1:0] COLOR_RESET    = 4'd15;

  // Microcode step addresses
  typedef enum logic [3:0] {
    S_IDLE = 4'd0,
    S_RAD  = 4'd1,
    S_LDR  = 4'd2,
    S_SQR  = 4'd3,
    S_LDSQ = 4'd4,
    S_MULT = 4'd5,
    S_DIVL = 4'd6,
    S_DIVS = 4'd7,
    S_ACC  = 4'd8,
    S_FIN1 = 4'd9,
    S_FIN2 = 4'd10,
    S_MULY = 4'd11,
    S_OUT  = 4'd12,
    S_DONE = 4'd13
  } step_e;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MS_NONE = 3'd0,
    MS_RAD  = 3'd1,
    MS_SQR  = 3'd2,
    MS_TERM = 3'd3,
    MS_Y    = 3'd4
  } mul_sel_e;

  // Datapath register operation
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_ACCEPT   = 4'd1,
    OP_LOAD_R   = 4'd2,
    OP_LOAD_SQ  = 4'd3,
    OP_DIV_LOAD = 4'd4,
    OP_DIV_STEP = 4'd5,
    OP_ACC      = 4'd6,
    OP_ABS      = 4'd7,
    OP_SCALE    = 4'd8,
    OP_EMIT     = 4'd9
  } dp_op_e;

  // Branch condition: taken goes to the target, else to the next step
  typedef enum logic [2:0] {
    JC_NEVER       = 3'd0,
    JC_ALWAYS      = 3'd1,
    JC_NO_REQ      = 3'd2,
    JC_DIV_MORE    = 3'd3,
    JC_SERIES_MORE = 3'd4,
    JC_OUT_BUSY    = 3'd5
  } jmp_cond_e;

  typedef struct packed {
    mul_sel_e  mul_sel;
    dp_op_e    op;
    jmp_cond_e cond;
    step_e     target;
  } ucode_t;

  // Status flags from the datapath for branch decisions
  typedef struct packed {
    logic req;
    logic div_more;
    logic series_more;
    logic out_busy;
  } dspp_stat_t;

  // Control store
  function automatic ucode_t dspp_ucode(input step_e step);
    ucode_t uc;
    unique case (step)
      S_IDLE:  uc = '{MS_NONE, OP_ACCEPT,   JC_NO_REQ,      S_IDLE};
      S_RAD:   uc = '{MS_RAD,  OP_NONE,     JC_NEVER,       S_IDLE};
      S_LDR:   uc = '{MS_NONE, OP_LOAD_R,   JC_NEVER,       S_IDLE};
      S_SQR:   uc = '{MS_SQR,  OP_NONE,     JC_NEVER,       S_IDLE};
      S_LDSQ:  uc = '{MS_NONE, OP_LOAD_SQ,  JC_NEVER,       S_IDLE};
      S_MULT:  uc = '{MS_TERM, OP_NONE,     JC_NEVER,       S_IDLE};
      S_DIVL:  uc = '{MS_NONE, OP_DIV_LOAD, JC_NEVER,       S_IDLE};
      S_DIVS:  uc = '{MS_NONE, OP_DIV_STEP, JC_DIV_MORE,    S_DIVS};
      S_ACC:   uc = '{MS_NONE, OP_ACC,      JC_SERIES_MORE, S_MULT};
      S_FIN1:  uc = '{MS_NONE, OP_ABS,      JC_NEVER,       S_IDLE};
      S_FIN2:  uc = '{MS_NONE, OP_SCALE,    JC_NEVER,       S_IDLE};
      S_MULY:  uc = '{MS_Y,    OP_NONE,     JC_NEVER,       S_IDLE};
      S_OUT:   uc = '{MS_NONE, OP_EMIT,     JC_OUT_BUSY,    S_OUT};
      S_DONE:  uc = '{MS_NONE, OP_NONE,     JC_ALWAYS,      S_IDLE};
      default: uc = '{MS_NONE, OP_NONE,     JC_ALWAYS,      S_IDLE};
    endcase
    return uc;
  endfunction

  // Series divisor (2k-2)(2k-1) for term index k
  function automatic logic [DIV_W-1:0] dspp_divisor(input logic [KIDX_W-1:0] k);
    logic [KIDX_W:0] two_k;
    logic [KIDX_W-1:0] f_lo;
    logic [KIDX_W-1:0] f_hi;
    two_k = {k, 1'b0};
    f_lo  = KIDX_W'(two_k - 7'd2);
    f_hi  = KIDX_W'(two_k - 7'd1);
    return DIV_W'(f_lo) * DIV_W'(f_hi);
  endfunction

endpackage

// ===== rtl/core/dspp_in_if.sv =====
// Request channel carrying one angle in degrees.
interface dspp_in_if import dspp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink   (input valid, input angle_deg, output ready);
endinterface

// ===== rtl/core/dspp_out_if.sv =====
// Result channel carrying the sine and its plot point.
interface dspp_out_if import dspp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SINE_W-1:0] sine_value;
  logic [PIX_W-1:0]         pixel_x;
  logic [PIX_W-1:0]         pixel_y;
  logic [COLOR_W-1:0]       point_color;

  modport source (output valid, output sine_value, output pixel_x, output pixel_y,
                  output point_color, input ready);
  modport sink   (input valid, input sine_value, input pixel_x, input pixel_y,
                  input point_color, output ready);
endinterface

// ===== rtl/core/dspp_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branch logic.
module dspp_seq import dspp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dspp_stat_t stat_i,
  output ucode_t     ctrl_o
);

  step_e  pc_q, pc_d;
  ucode_t uc;
  logic   taken;

  // Fetch the control word of the current step
  assign uc     = dspp_ucode(pc_q);
  assign ctrl_o = uc;

  // Evaluate the branch condition
  always_comb begin
    unique case (uc.cond)
      JC_NEVER:       taken = 1'b0;
      JC_ALWAYS:      taken = 1'b1;
      JC_NO_REQ:      taken = !stat_i.req;
      JC_DIV_MORE:    taken = stat_i.div_more;
      JC_SERIES_MORE: taken = stat_i.series_more;
      JC_OUT_BUSY:    taken = stat_i.out_busy;
      default:        taken = 1'b1;
    endcase
  end

  assign pc_d = taken ? uc.target : step_e'(pc_q + 4'd1);

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/core/dspp_datapath.sv =====
// Datapath: shared multiplier, digit divider, series accumulator and output register.
module dspp_datapath import dspp_pkg::*; #(
  parameter int TERMS     = DEF_TERMS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ucode_t             ctrl_i,
  input  logic [COLOR_W-1:0] color_i,
  output dspp_stat_t         stat_o,
  dspp_in_if.sink            in_i,
  dspp_out_if.source         out_o
);

  localparam int KW   = $clog2(TERMS + 1);
  localparam int MQW  = FRAC_BITS + 1;
  localparam int MW   = MAG_W + FRAC_BITS + 1;
  localparam int EW   = (MQW > SINE_W + 1) ? MQW : SINE_W + 1;
  localparam logic [MW-1:0] ROUND_ADD =
    (FRAC_BITS < WORK_FRAC) ? (MW'(1) << (WORK_FRAC - 1)) : '0;
  localparam logic [MW-1:0] ONE_Q = MW'(1) << FRAC_BITS;
  localparam logic [EW-1:0] POS_MAX = EW'(32767);
  localparam logic [EW-1:0] NEG_MAX = EW'(32768);

  // Request side
  logic              accept;
  logic [ANGLE_W-1:0] angle_u;
  logic [ANGLE_W-1:0] mag_d;
  logic signed [10:0] angle_x;
  logic signed [10:0] half_sum;
  logic signed [10:0] half_angle;
  logic signed [10:0] px_full;

  // Working registers
  logic               neg_angle_q;
  logic [ANGLE_W-1:0] mag_q;
  logic [PIX_W-1:0]   px_q;
  logic [SQ_W-1:0]    sq_q;
  logic [TERM_W-1:0]  term_q;
  logic [SUM_W-1:0]   sum_q;
  logic               minus_q;
  logic [KW-1:0]      k_q;
  logic [PROD_W-1:0]  p_q;
  logic [TERM_W-1:0]  qx_q;
  logic [DIV_W-1:0]   rem_q;
  logic [DIV_W-1:0]   d_q;
  logic [1:0]         dcnt_q;
  logic [MAG_W-1:0]   m20_q;
  logic               neg_q;
  logic [MQW-1:0]     mq_q;

  // Combinational helpers
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [47:0]        sq_round;
  logic [TERM_W-1:0]  qx_step;
  logic [DIV_W-1:0]   rem_step;
  logic [SUM_W-1:0]   sum_acc;
  logic [MAG_W-1:0]   m20_d;
  logic [MW-1:0]      m_full;
  logic [MQW-1:0]     mq_d;
  logic [EW-1:0]      mq_ext;
  logic [EW-1:0]      mq_neg;
  logic [SINE_W-1:0]  sine_d;
  logic [YOFF_W-1:0]  yoff;
  logic [PIX_W-1:0]   py_d;

  // Output register
  logic               out_valid_q;
  logic [SINE_W-1:0]  sine_q;
  logic [PIX_W-1:0]   pix_x_q;
  logic [PIX_W-1:0]   pix_y_q;
  logic [COLOR_W-1:0] color_q;
  logic               out_busy;
  logic               emit;

  // Take a request only at the idle step
  assign in_i.ready = (ctrl_i.op == OP_ACCEPT);
  assign accept     = in_i.valid && in_i.ready;

  // Magnitude and screen column of the angle
  assign angle_u    = in_i.angle_deg;
  assign mag_d      = angle_u[ANGLE_W-1] ? (~angle_u + 10'd1) : angle_u;
  assign angle_x    = 11'(in_i.angle_deg);
  assign half_sum   = angle_x + $signed({10'b0, angle_u[ANGLE_W-1]});
  assign half_angle = half_sum >>> 1;
  assign px_full    = ORIGIN_X + half_angle;

  // Select operands for the shared multiplier
  always_comb begin
    case (ctrl_i.mul_sel)
      MS_RAD: begin
        mul_a = MUL_A_W'(mag_q);
        mul_b = MUL_B_W'(DEG_TO_RAD_Q20);
      end
      MS_SQR: begin
        mul_a = MUL_A_W'(term_q[RAD_W-1:0]);
        mul_b = MUL_B_W'(term_q[RAD_W-1:0]);
      end
      MS_TERM: begin
        mul_a = term_q;
        mul_b = sq_q;
      end
      MS_Y: begin
        mul_a = MUL_A_W'(mq_q);
        mul_b = MUL_B_W'(Y_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Round the square back to Q20
  assign sq_round = p_q[47:0] + (48'd1 << (WORK_FRAC - 1));

  // Resolve a group of quotient bits by restoring compare and subtract
  always_comb begin
    logic [DIV_W:0] trial;
    qx_step  = qx_q;
    rem_step = rem_q;
    for (int i = 0; i < DIG_BITS; i++) begin
      trial = {rem_step, qx_step[TERM_W-1]};
      if (trial >= {1'b0, d_q}) begin
        rem_step = DIV_W'(trial - {1'b0, d_q});
        qx_step  = {qx_step[TERM_W-2:0], 1'b1};
      end else begin
        rem_step = trial[DIV_W-1:0];
        qx_step  = {qx_step[TERM_W-2:0], 1'b0};
      end
    end
  end

  // Add or subtract the new term
  assign sum_acc = minus_q ? (sum_q - SUM_W'(qx_q)) : (sum_q + SUM_W'(qx_q));

  // Magnitude of the sum
  assign m20_d = sum_q[SUM_W-1] ? MAG_W'(~sum_q + SUM_W'(1)) : MAG_W'(sum_q);

  // Rescale to the output format, rounding half up, then saturate at one
  assign m_full = ((MW'(m20_q) << FRAC_BITS) + ROUND_ADD) >> WORK_FRAC;
  assign mq_d   = (m_full > ONE_Q) ? MQW'(ONE_Q) : m_full[MQW-1:0];

  // Signed sine clamped to the output field
  assign mq_ext = EW'(mq_q);
  assign mq_neg = EW'(0) - mq_ext;
  always_comb begin
    if (neg_q) begin
      sine_d = (mq_ext > NEG_MAX) ? 16'h8000 : mq_neg[SINE_W-1:0];
    end else begin
      sine_d = (mq_ext > POS_MAX) ? 16'h7fff : mq_ext[SINE_W-1:0];
    end
  end

  // Screen row from the hundredfold sine
  assign yoff = p_q[FRAC_BITS +: YOFF_W];
  assign py_d = neg_q ? (ORIGIN_Y + PIX_W'(yoff)) : (ORIGIN_Y - PIX_W'(yoff));

  // Status to the sequencer
  assign out_busy           = out_valid_q && !out_o.ready;
  assign emit               = (ctrl_i.op == OP_EMIT) && !out_busy;
  assign stat_o.req         = in_i.valid;
  assign stat_o.div_more    = (dcnt_q != 2'd3);
  assign stat_o.series_more = (qx_q != '0) && (k_q != KW'(TERMS));
  assign stat_o.out_busy    = out_busy;

  // Control registers of the series loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      minus_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      case (ctrl_i.op)
        OP_LOAD_R: begin
          k_q     <= KW'(2);
          minus_q <= 1'b1;
        end
        OP_DIV_LOAD: dcnt_q <= '0;
        OP_DIV_STEP: dcnt_q <= dcnt_q + 2'd1;
        OP_ACC: begin
          k_q     <= k_q + KW'(1);
          minus_q <= !minus_q;
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the working datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_sel != MS_NONE) begin
      p_q <= prod;
    end
    if (accept) begin
      neg_angle_q <= angle_u[ANGLE_W-1];
      mag_q       <= mag_d;
      px_q        <= px_full[PIX_W-1:0];
    end
    case (ctrl_i.op)
      OP_LOAD_R: begin
        term_q <= TERM_W'(p_q[RAD_W-1:0]);
        sum_q  <= SUM_W'(p_q[RAD_W-1:0]);
      end
      OP_LOAD_SQ: sq_q <= sq_round[WORK_FRAC +: SQ_W];
      OP_DIV_LOAD: begin
        qx_q  <= p_q[WORK_FRAC +: TERM_W];
        rem_q <= DIV_W'(p_q[PROD_W-1:WORK_FRAC+TERM_W]);
        d_q   <= dspp_divisor(KIDX_W'(k_q));
      end
      OP_DIV_STEP: begin
        qx_q  <= qx_step;
        rem_q <= rem_step;
      end
      OP_ACC: begin
        term_q <= qx_q;
        sum_q  <= sum_acc;
      end
      OP_ABS: begin
        m20_q <= m20_d;
        neg_q <= sum_q[SUM_W-1] ^ neg_angle_q;
      end
      OP_SCALE: mq_q <= mq_d;
      default: ;
    endcase
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sine_q  <= sine_d;
      pix_x_q <= px_q;
      pix_y_q <= py_d;
      color_q <= color_i;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sine_value  = sine_q;
  assign out_o.pixel_x     = pix_x_q;
  assign out_o.pixel_y     = pix_y_q;
  assign out_o.point_color = color_q;

endmodule

// ===== rtl/core/degree_sine_plot_point.sv =====
// Top level of the degree sine plot point block.
// Takes an angle in whole degrees and returns its sine in signed Q1.FRAC_BITS
// (Q1.14 by default) together with a plot point x = 320 + angle/2 and
// y = 240 - trunc(100*sine) tagged with the configured color. The sine comes
// from a Maclaurin series summed term by term on one shared multiplier and a
// divider that resolves eight quotient bits per cycle, under control of a
// microcode sequencer. Each item passes through steps that turn the angle into
// radians and square it, then a loop over the series terms after the first
// (1 to TERMS-1, stopping early when a term reaches zero) in which each term
// takes a multiply, a divider load, the divider steps and an accumulate, then
// final steps for magnitude, rescale, plot row and output; the last step waits
// for as long as an earlier result of the block still sits unclaimed in the
// output register. The result sits in an output register, and the block
// returns to idle once it is loaded there; a further request is taken while
// an earlier result still waits. Write the color register only while the
// block is idle.
module degree_sine_plot_point import dspp_pkg::*; #(
  parameter int TERMS     = DEF_TERMS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COLOR_W-1:0] cfg_data_i,
  dspp_in_if.sink            in_i,
  dspp_out_if.source         out_o
);

  localparam int SINE_ONE = 1 << FRAC_BITS;

  logic [COLOR_W-1:0] color_q;
  ucode_t             ctrl;
  dspp_stat_t         stat;

  // Hold the color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (cfg_we_i) begin
      color_q <= cfg_data_i;
    end
  end

  dspp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  dspp_datapath #(
    .TERMS     (TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .color_i (color_q),
    .stat_o  (stat),
    .in_i    (in_i),
    .out_o   (out_o)
  );

  // A request starts a computation, so none is taken in the following cycle
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request accepted while a computation was running");

  // The row lies on the side of the axis that the sine sign calls for
  a_row_follows_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.sine_value[SINE_W-1] ? (out_o.pixel_y >= ORIGIN_Y)
                                                 : (out_o.pixel_y <= ORIGIN_Y)))
    else $error("pixel row on the wrong side of the axis");

  // The sine never exceeds one in magnitude
  a_sine_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (FRAC_BITS <= 14) |->
      ($signed(out_o.sine_value) <= SINE_ONE) && ($signed(out_o.sine_value) >= -SINE_ONE))
    else $error("sine beyond unit magnitude");

endmodule
